@@ sv/lgtr_pkg.sv @@
// lgtr_pkg: shared types and constants for the topic resampler
// no dependencies; imported by the interfaces and by every module except lgtr_ram
package lgtr_pkg;

  localparam int KIND_W   = 2;
  localparam int ITEM_W   = 10;
  localparam int WORD_W   = 12;
  localparam int TOPIC_W  = 3;
  localparam int WEIGHT_W = 16;
  localparam int DRAW_W   = 16;
  localparam int ALPHA_W  = 16;
  localparam int TOTAL_BITS = 24;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd2560;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ASSIGN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESAMPLE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ITEM_W-1:0]   item_index;
    logic [WORD_W-1:0]   word_index;
    logic [TOPIC_W-1:0]  topic_index;
    logic [WEIGHT_W-1:0] weight_value;
    logic [DRAW_W-1:0]   uniform_draw;
  } item_t;

endpackage

@@ sv/lgtr_ifs.sv @@
// lgtr_in_if / lgtr_out_if: valid-ready channels of the topic resampler
// depends on lgtr_pkg
interface lgtr_in_if import lgtr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ITEM_W-1:0]   item_index;
  logic [WORD_W-1:0]   word_index;
  logic [TOPIC_W-1:0]  topic_index;
  logic [WEIGHT_W-1:0] weight_value;
  logic [DRAW_W-1:0]   uniform_draw;

  modport source (output valid, kind, item_index, word_index, topic_index,
                  weight_value, uniform_draw, input ready);
  modport sink   (input valid, kind, item_index, word_index, topic_index,
                  weight_value, uniform_draw, output ready);
endinterface

interface lgtr_out_if import lgtr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOPIC_W-1:0] sampled_topic;
  logic               count_underflow;

  modport source (output valid, sampled_topic, count_underflow, input ready);
  modport sink   (input valid, sampled_topic, count_underflow, output ready);
endinterface

@@ sv/lgtr_ram.sv @@
// lgtr_ram: generic simple dual-port RAM with registered read
// no dependencies
module lgtr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/lgtr_front.sv @@
// lgtr_front: accepts input transfers, drops reserved kinds, queues the rest
// depends on lgtr_pkg and lgtr_in_if
module lgtr_front import lgtr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        busy,
  lgtr_in_if.sink     in_ch,
  output item_t       q_head,
  output logic        q_valid,
  input  logic        q_pop
);

  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  item_t            q_r [QD];
  logic [QAW-1:0]   wp_r;
  logic [QAW-1:0]   rp_r;
  logic [QAW:0]     cnt_r;
  logic             acc;
  logic             push;
  item_t            in_item;

  assign in_ch.ready = !busy && (cnt_r != (QAW+1)'(QD));
  assign acc         = in_ch.valid && in_ch.ready;
  assign push        = acc && (in_ch.kind != KIND_RESERVED);
  assign q_valid     = (cnt_r != '0);
  assign q_head      = q_r[rp_r];

  always_comb begin
    in_item.kind         = in_ch.kind;
    in_item.item_index   = in_ch.item_index;
    in_item.word_index   = in_ch.word_index;
    in_item.topic_index  = in_ch.topic_index;
    in_item.weight_value = in_ch.weight_value;
    in_item.uniform_draw = in_ch.uniform_draw;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end
  end

endmodule

@@ sv/lgtr_back.sv @@
// lgtr_back: count and weight memories, removal, per-topic divide, draw scan, add
// depends on lgtr_pkg, lgtr_ram and lgtr_out_if
module lgtr_back import lgtr_pkg::*; #(
  parameter int TOPICS     = 5,
  parameter int VOCAB      = 4096,
  parameter int ITEMS      = 1024,
  parameter int COUNT_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ALPHA_W-1:0] alpha,
  input  item_t              q_head,
  input  logic               q_valid,
  output logic               q_pop,
  output logic               busy,
  lgtr_out_if.source         out_ch
);

  localparam int TKW  = $clog2(TOPICS);
  localparam int VAW  = $clog2(VOCAB);
  localparam int IAW  = (ITEMS > 1) ? $clog2(ITEMS) : 1;
  localparam int CW   = COUNT_BITS;
  localparam int NUMW = CW + 9;
  localparam int WNW  = WEIGHT_W + NUMW;
  localparam int PW   = WNW + 8;
  localparam int DW   = TOTAL_BITS + 9;
  localparam int SW   = PW + TKW;
  localparam int DCW  = $clog2(PW + 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_REMOVE = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_THRESH = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_ADD    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0]            state_r;
  logic [VAW-1:0]        clr_r;
  item_t                 cur_r;
  logic [TKW-1:0]        k_r;
  logic [TKW-1:0]        nt_r;
  logic                  rm_hit_r;
  logic                  flag_r;
  logic [TOTAL_BITS-1:0] tot_r [TOPICS];
  logic [SW-1:0]         acc_r;
  logic [SW-1:0]         acc_nxt;
  logic [SW-1:0]         sums_r [TOPICS];
  logic [SW-1:0]         u_r;
  logic [PW-1:0]         quo_r;
  logic [DW-1:0]         rem_r;
  logic [DW-1:0]         den_r;
  logic [DCW-1:0]        dcnt_r;
  logic                  out_valid_r;
  logic [TOPIC_W-1:0]    out_topic_r;
  logic                  out_flag_r;

  logic [CW-1:0]         cnt_rd [TOPICS];
  logic [WEIGHT_W-1:0]   wt_rd [TOPICS];
  logic [TOPICS-1:0]     cnt_we;
  logic [VAW-1:0]        cnt_wa;
  logic [CW-1:0]         cnt_wd;
  logic [TOPICS-1:0]     wt_we;

  logic                  topic_ok, word_ok, item_ok, rm_ok, add_ok, is_rs;
  logic                  h_topic_ok, h_item_ok;
  logic [TKW-1:0]        sel, add_t, cur_t;
  logic [CW-1:0]         cnt_raw, cnt_eff, cnt_use;
  logic [WEIGHT_W-1:0]   w_use;
  logic [TOTAL_BITS-1:0] tot_sel;
  logic [NUMW-1:0]       num;
  logic [WNW-1:0]        wn;
  logic [DW-1:0]         den_tmp, den_nxt;
  logic [DW:0]           trial, diff;
  logic                  ge;
  logic [SW+15:0]        ud;
  logic                  out_fire;

  // item classification
  assign is_rs      = (cur_r.kind == KIND_RESAMPLE);
  assign topic_ok   = 32'(cur_r.topic_index) < TOPICS;
  assign word_ok    = 32'(cur_r.word_index) < VOCAB;
  assign item_ok    = 32'(cur_r.item_index) < ITEMS;
  assign rm_ok      = topic_ok && word_ok;
  assign add_ok     = (is_rs || topic_ok) && word_ok;
  assign h_topic_ok = 32'(q_head.topic_index) < TOPICS;
  assign h_item_ok  = 32'(q_head.item_index) < ITEMS;
  assign cur_t      = TKW'(cur_r.topic_index);
  assign add_t      = is_rs ? nt_r : cur_t;

  assign busy  = (state_r == S_CLEAR);
  assign q_pop = (state_r == S_IDLE) && q_valid;

  // topic select for the shared datapath
  always_comb begin
    case (state_r)
      S_REMOVE: sel = cur_t;
      S_ADD:    sel = add_t;
      default:  sel = k_r;
    endcase
  end

  // count seen after removal, weight and total for the selected topic
  assign cnt_raw = cnt_rd[sel];
  assign cnt_eff = cnt_raw - CW'(rm_hit_r && (sel == cur_t));
  assign cnt_use = word_ok ? cnt_eff : '0;
  assign w_use   = item_ok ? wt_rd[sel] : '0;
  assign tot_sel = tot_r[sel];

  // weight times smoothed count, smoothed denominator
  assign num     = NUMW'({cnt_use, 8'h00}) + NUMW'(alpha);
  assign wn      = WNW'(w_use) * WNW'(num);
  assign den_tmp = DW'({tot_sel, 8'h00}) + DW'(alpha) * DW'(TOPICS);
  assign den_nxt = (den_tmp <= DW'(256)) ? DW'(1) : den_tmp - DW'(256);

  // one restoring divide step
  assign trial = {rem_r, quo_r[PW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  assign acc_nxt = acc_r + SW'(quo_r);
  assign ud      = (SW+16)'(acc_r) * (SW+16)'(cur_r.uniform_draw);

  // memory write control
  always_comb begin
    cnt_we = '0;
    cnt_wa = VAW'(cur_r.word_index);
    cnt_wd = '0;
    wt_we  = '0;
    case (state_r)
      S_CLEAR: begin
        cnt_we = '1;
        cnt_wa = clr_r;
      end
      S_REMOVE: begin
        cnt_wd = cnt_raw - 1'b1;
        for (int k = 0; k < TOPICS; k++) begin
          cnt_we[k] = rm_ok && (cnt_raw != '0) && (32'(sel) == k);
        end
      end
      S_ADD: begin
        cnt_wd = cnt_eff + 1'b1;
        for (int k = 0; k < TOPICS; k++) begin
          cnt_we[k] = add_ok && (cnt_eff != '1) && (32'(sel) == k);
        end
      end
      S_IDLE: begin
        for (int k = 0; k < TOPICS; k++) begin
          wt_we[k] = q_valid && (q_head.kind == KIND_LOAD) && h_item_ok && h_topic_ok
                     && (32'(q_head.topic_index) == k);
        end
      end
      default: ;
    endcase
  end

  // one count bank and one weight bank per topic
  for (genvar g = 0; g < TOPICS; g++) begin : g_bank
    lgtr_ram #(.WIDTH(CW), .DEPTH(VOCAB)) u_cnt (
      .clk   (clk),
      .we    (cnt_we[g]),
      .waddr (cnt_wa),
      .wdata (cnt_wd),
      .re    (q_pop),
      .raddr (VAW'(q_head.word_index)),
      .rdata (cnt_rd[g])
    );
    lgtr_ram #(.WIDTH(WEIGHT_W), .DEPTH(ITEMS)) u_wt (
      .clk   (clk),
      .we    (wt_we[g]),
      .waddr (IAW'(q_head.item_index)),
      .wdata (q_head.weight_value),
      .re    (q_pop),
      .raddr (IAW'(q_head.item_index)),
      .rdata (wt_rd[g])
    );
  end

  assign out_fire = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < TOPICS; k++) begin
        tot_r[k] <= '0;
      end
    end else begin
      if (out_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == VAW'(VOCAB - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            case (q_head.kind)
              KIND_ASSIGN:   state_r <= S_ADD;
              KIND_RESAMPLE: state_r <= S_REMOVE;
              default:       state_r <= S_IDLE;
            endcase
          end
        end
        S_REMOVE: begin
          if (rm_ok && (tot_sel != '0)) begin
            for (int k = 0; k < TOPICS; k++) begin
              if (32'(sel) == k) begin
                tot_r[k] <= tot_sel - 1'b1;
              end
            end
          end
          state_r <= S_MUL;
        end
        S_MUL: state_r <= S_DIV;
        S_DIV: begin
          if (dcnt_r == DCW'(PW - 1)) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (k_r == TKW'(TOPICS - 1)) begin
            state_r <= S_THRESH;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_THRESH: state_r <= S_SCAN;
        S_SCAN: begin
          if ((sums_r[k_r] >= u_r) || (k_r == TKW'(TOPICS - 1))) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (add_ok && (tot_sel != '1)) begin
            for (int k = 0; k < TOPICS; k++) begin
              if (32'(sel) == k) begin
                tot_r[k] <= tot_sel + 1'b1;
              end
            end
          end
          state_r <= is_rs ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (out_fire) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cur_r    <= q_head;
        rm_hit_r <= 1'b0;
        flag_r   <= 1'b0;
      end
      S_REMOVE: begin
        rm_hit_r <= rm_ok && (cnt_raw != '0);
        flag_r   <= rm_ok && ((cnt_raw == '0) || (tot_sel == '0));
        k_r      <= '0;
        acc_r    <= '0;
      end
      S_MUL: begin
        quo_r  <= {wn, 8'h00};
        den_r  <= den_nxt;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        rem_r  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_r  <= {quo_r[PW-2:0], ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
      S_ACC: begin
        acc_r       <= acc_nxt;
        sums_r[k_r] <= acc_nxt;
        if (k_r != TKW'(TOPICS - 1)) begin
          k_r <= k_r + 1'b1;
        end
      end
      S_THRESH: begin
        u_r <= ud[SW+15:16];
        k_r <= '0;
      end
      S_SCAN: begin
        nt_r <= k_r;
        k_r  <= k_r + 1'b1;
      end
      S_OUT: begin
        if (out_fire) begin
          out_topic_r <= TOPIC_W'(nt_r);
          out_flag_r  <= flag_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sampled_topic   = out_topic_r;
  assign out_ch.count_underflow = out_flag_r;

endmodule

@@ sv/lda_gibbs_topic_resampler_core.sv @@
// lda_gibbs_topic_resampler_core: collapsed Gibbs topic resampler, top level
// after reset a clearing pass zeroes the counts of every word; no transfer is taken then
// a load is written from the queue head in the idle state; an assign goes on to the add state;
// a resample removes, then per topic multiplies and divides bit-serially (PW = COUNT_BITS+33), then scans and adds
// one item is in work at a time; a four-entry queue and an output register decouple the sides
// reset is synchronous active low; alpha returns to 10.0, counts and totals to zero
module lda_gibbs_topic_resampler_core import lgtr_pkg::*; #(
  parameter int TOPICS     = 5,
  parameter int VOCAB      = 4096,
  parameter int ITEMS      = 1024,
  parameter int COUNT_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ALPHA_W-1:0] cfg_wdata,
  lgtr_in_if.sink            in_ch,
  lgtr_out_if.source         out_ch
);

  logic [ALPHA_W-1:0] alpha_r;
  item_t              q_head;
  logic               q_valid;
  logic               q_pop;
  logic               busy;

  // smoothing register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_we) begin
      alpha_r <= cfg_wdata;
    end
  end

  lgtr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (busy),
    .in_ch   (in_ch),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  lgtr_back #(
    .TOPICS     (TOPICS),
    .VOCAB      (VOCAB),
    .ITEMS      (ITEMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .alpha   (alpha_r),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .busy    (busy),
    .out_ch  (out_ch)
  );

endmodule

@@ verif/lda_gibbs_topic_resampler_core_tb.sv @@
// lda_gibbs_topic_resampler_core_tb: self-checking bench for the topic resampler core
// depends on lgtr_pkg, lgtr_ifs and the core; predicts each sampled topic and underflow flag
module lda_gibbs_topic_resampler_core_tb;
  import lgtr_pkg::*;

  localparam int NTOP  = 5;
  localparam int NWORD = 4096;
  localparam int NITEM = 1024;
  localparam longint unsigned CNT_MAX = (64'd1 << 20) - 1;
  localparam longint unsigned TOT_MAX = (64'd1 << TOTAL_BITS) - 1;
  localparam int SETTLE = 400;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [TOPIC_W-1:0] topic;
    logic               underflow;
  } sample_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ALPHA_W-1:0] cfg_wdata;

  lgtr_in_if  in_ch ();
  lgtr_out_if out_ch ();

  lda_gibbs_topic_resampler_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predicted block state
  logic [19:0]          word_cnt [NTOP*NWORD];
  logic [TOTAL_BITS-1:0] topic_tot [NTOP];
  logic [15:0]          doc_weight [NITEM*NTOP];
  logic [ALPHA_W-1:0]   alpha_q88;

  // stimulus bookkeeping
  item_t   pending_items [$];
  sample_t expected_samples [$];
  logic [NTOP-1:0] weight_mask [NITEM];
  int      loaded_docs [$];
  bit      failed;
  bit      no_gaps;
  bit      hold_go;

  // clock and known input values from time zero
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.item_index = '0;
    in_ch.word_index = '0;
    in_ch.topic_index = '0;
    in_ch.weight_value = '0;
    in_ch.uniform_draw = '0;
    out_ch.ready = 1'b0;
    forever #6 clk = ~clk;
  end

  // add one token, saturating
  task automatic add_token(int unsigned topic, int unsigned word);
    if (topic >= NTOP) return;
    if (word_cnt[topic*NWORD+word] < CNT_MAX) word_cnt[topic*NWORD+word]++;
    if (topic_tot[topic] < TOT_MAX) topic_tot[topic]++;
  endtask

  // draw a topic from the collapsed conditional
  function automatic int unsigned draw_topic(int unsigned doc, int unsigned word,
                                             longint unsigned u16);
    longint unsigned sums [NTOP];
    longint unsigned acc;
    longint unsigned w;
    longint unsigned num;
    longint          den;
    longint unsigned last;
    longint unsigned thr;
    acc = 0;
    for (int k = 0; k < NTOP; k++) begin
      w = doc_weight[doc*NTOP+k];
      num = longint'(word_cnt[k*NWORD+word]) * 256 + alpha_q88;
      den = longint'(topic_tot[k]) * 256 + NTOP * longint'(alpha_q88) - 256;
      if (den < 1) den = 1;
      acc += (w * num * 256) / longint'(den);
      sums[k] = acc;
    end
    last = sums[NTOP-1];
    thr = (last >> 16) * u16 + (((last & 64'hFFFF) * u16) >> 16);
    for (int k = 0; k < NTOP; k++)
      if (sums[k] >= thr) return k;
    return NTOP - 1;
  endfunction

  // update predicted state for one accepted transfer
  task automatic apply_transfer(item_t t);
    int unsigned idx;
    int unsigned nt;
    sample_t s;
    idx = t.topic_index * NWORD + t.word_index;
    case (t.kind)
      KIND_LOAD: begin
        if (t.topic_index < NTOP) doc_weight[t.item_index*NTOP+t.topic_index] = t.weight_value;
      end
      KIND_ASSIGN: add_token(t.topic_index, t.word_index);
      KIND_RESAMPLE: begin
        s.underflow = 1'b0;
        if (t.topic_index < NTOP) begin
          if (word_cnt[idx] == 0) s.underflow = 1'b1; else word_cnt[idx]--;
          if (topic_tot[t.topic_index] == 0) s.underflow = 1'b1;
          else topic_tot[t.topic_index]--;
        end
        nt = draw_topic(t.item_index, t.word_index, t.uniform_draw);
        add_token(nt, t.word_index);
        s.topic = nt[TOPIC_W-1:0];
        expected_samples = {expected_samples, s};
      end
      default: ;
    endcase
  endtask

  // queue an item; track which documents have every weight written
  task automatic queue_item(item_t t);
    if (t.kind == KIND_LOAD && t.topic_index < NTOP) begin
      if (weight_mask[t.item_index] != '1) begin
        weight_mask[t.item_index][t.topic_index] = 1'b1;
        if (weight_mask[t.item_index] == '1) loaded_docs = {loaded_docs, int'(t.item_index)};
      end
    end
    pending_items = {pending_items, t};
  endtask

  function automatic item_t make_item(logic [KIND_W-1:0] kind, int doc, int word, int topic,
                                      int wv, int u16);
    item_t t;
    t.kind = kind;
    t.item_index = ITEM_W'(doc);
    t.word_index = WORD_W'(word);
    t.topic_index = TOPIC_W'(topic);
    t.weight_value = WEIGHT_W'(wv);
    t.uniform_draw = DRAW_W'(u16);
    return t;
  endfunction

  // random item: mostly well-formed traffic over a small vocabulary
  task automatic queue_random;
    item_t t;
    int sel;
    sel = $urandom_range(0, 99);
    t = make_item(KIND_RESAMPLE, 0, 0, 0, $urandom, $urandom);
    t.word_index = WORD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 15));
    t.topic_index = TOPIC_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, NTOP-1));
    t.item_index = ITEM_W'($urandom_range(0, NITEM-1));
    if (sel < 15 || loaded_docs.size() == 0) begin
      t.kind = KIND_LOAD;
      // mostly fill weights of a few documents so they become usable
      if (loaded_docs.size() < 40 && $urandom_range(0, 1))
        t.item_index = ITEM_W'($urandom_range(0, 63));
    end else if (sel < 45) begin
      t.kind = KIND_ASSIGN;
    end else if (sel < 95) begin
      t.item_index = ITEM_W'(loaded_docs[$urandom_range(0, loaded_docs.size()-1)]);
    end else begin
      t.kind = KIND_RESERVED;
    end
    queue_item(t);
  endtask

  // wait until no transfer is pending or outstanding, then let the block settle
  task automatic wait_idle;
    while (pending_items.size() != 0 || in_ch.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_alpha(logic [ALPHA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    alpha_q88 = v;
  endtask

  // sender: offers queued items with random gaps, or back to back while no_gaps is set
  item_t cur_item;
  bit    offering;
  int    send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      offering = 1'b0;
      send_gap = 0;
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_transfer(cur_item);
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) send_gap--;
        else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          offering = 1'b1;
          send_gap = no_gaps ? 0 : $urandom_range(0, 10);
        end
      end
      in_ch.valid <= offering;
      in_ch.kind <= cur_item.kind;
      in_ch.item_index <= cur_item.item_index;
      in_ch.word_index <= cur_item.word_index;
      in_ch.topic_index <= cur_item.topic_index;
      in_ch.weight_value <= cur_item.weight_value;
      in_ch.uniform_draw <= cur_item.uniform_draw;
    end
  end

  // receiver: checks each result transfer, stalls at random unless no_gaps is set and once for a long stretch
  int  stall_left;
  int  hold_left;
  bit  hold_done;
  always @(posedge clk) begin
    sample_t e;
    bit rdy;
    if (!rst_n) begin
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sampled_topic %0d count_underflow %0d",
                 out_ch.sampled_topic, out_ch.count_underflow);
          failed = 1'b1;
        end else begin
          e = expected_samples.pop_front();
          if (out_ch.sampled_topic !== e.topic) begin
            $error("sampled_topic mismatch: expected %0d actual %0d", e.topic,
                   out_ch.sampled_topic);
            failed = 1'b1;
          end
          if (out_ch.count_underflow !== e.underflow) begin
            $error("count_underflow mismatch: expected %0d actual %0d",
                   e.underflow, out_ch.count_underflow);
            failed = 1'b1;
          end
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 3000;
      end
      rdy = 1'b0;
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      else rdy = 1'b1;
      out_ch.ready <= rdy;
    end
  end

  // run limit
  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    logic [ALPHA_W-1:0] alphas [4];
    failed = 1'b0;
    no_gaps = 1'b0;
    hold_go = 1'b0;
    cycles = 0;
    alpha_q88 = ALPHA_RESET;
    for (int i = 0; i < NTOP*NWORD; i++) word_cnt[i] = '0;
    for (int k = 0; k < NTOP; k++) topic_tot[k] = '0;
    for (int i = 0; i < NITEM*NTOP; i++) doc_weight[i] = '0;
    for (int i = 0; i < NITEM; i++) weight_mask[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: weight extremes, ignored topics, underflow, skipped removal, reserved kind
    queue_item(make_item(KIND_LOAD, 0, 0, 0, 65535, 0));
    queue_item(make_item(KIND_LOAD, 0, 0, 1, 0, 0));
    queue_item(make_item(KIND_LOAD, 0, 0, 2, 1, 0));
    queue_item(make_item(KIND_LOAD, 0, 0, 3, 32768, 0));
    queue_item(make_item(KIND_LOAD, 0, 0, 4, 65535, 0));
    queue_item(make_item(KIND_LOAD, 0, 0, 7, 123, 0));
    for (int k = 0; k < NTOP; k++) queue_item(make_item(KIND_LOAD, 1023, 4095, k, 65535, 0));
    queue_item(make_item(KIND_ASSIGN, 0, 0, 0, 0, 0));
    queue_item(make_item(KIND_ASSIGN, 0, 4095, 4, 0, 0));
    queue_item(make_item(KIND_ASSIGN, 0, 7, 6, 0, 0));
    queue_item(make_item(KIND_RESAMPLE, 0, 0, 0, 0, 0));
    queue_item(make_item(KIND_RESAMPLE, 0, 0, 0, 0, 65535));
    queue_item(make_item(KIND_RESAMPLE, 0, 9, 2, 0, 32768));
    queue_item(make_item(KIND_RESAMPLE, 0, 4095, 7, 0, 65535));
    queue_item(make_item(KIND_RESAMPLE, 1023, 4095, 4, 65535, 65535));
    queue_item(make_item(KIND_RESAMPLE, 1023, 0, 5, 0, 1));
    queue_item(make_item(KIND_RESERVED, 1023, 4095, 7, 65535, 65535));
    for (int i = 0; i < 330; i++) queue_random();
    wait_idle();

    alphas[0] = 16'd256;
    alphas[1] = 16'd65535;
    alphas[2] = ALPHA_W'($urandom_range(256, 65535));
    alphas[3] = ALPHA_RESET;
    for (int p = 0; p < 4; p++) begin
      write_alpha(alphas[p]);
      no_gaps = (p == 2);
      if (p == 1) begin
        // stall the result side while resamples keep coming
        for (int i = 0; i < 12; i++)
          queue_item(make_item(KIND_RESAMPLE, loaded_docs[0], $urandom_range(0, 15),
                               $urandom_range(0, NTOP-1), 0, $urandom));
        @(posedge clk);
        hold_go <= 1'b1;
      end
      for (int i = 0; i < 350; i++) queue_random();
      wait_idle();
    end

    if (expected_samples.size() != 0) begin
      $error("%0d expected results never arrived", expected_samples.size());
      failed = 1'b1;
    end
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
